// ===== rtl/core/plfr_pkg.sv =====
// Package for the preamble and length frame receiver.
// Holds the word types, glyph codes and framing constants used by all modules.
// No dependencies.
package plfr_pkg;

    localparam int BUFFER_DEPTH_DEF = 32;

    localparam logic [7:0] PRE_A      = 8'hAA;
    localparam logic [7:0] PRE_B      = 8'h55;
    localparam logic [7:0] UNDERSCORE = 8'h5F;

    localparam logic [2:0] PH_LENGTH = 3'd4;
    localparam logic [2:0] PH_BODY   = 3'd5;

    typedef enum logic [1:0] {
        GLYPH_NONE  = 2'd0,
        GLYPH_CHAR  = 2'd1,
        GLYPH_SPACE = 2'd2
    } glyph_kind_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic [5:0] fifo_free;
    } plfr_in_t;

    typedef struct packed {
        logic        push_valid;
        logic [7:0]  push_data;
        logic        frame_done;
        logic        link_seen;
        logic        text_start;
        glyph_kind_t glyph_kind;
        logic [7:0]  text_char;
        logic        separator;
        logic        text_done;
    } plfr_out_t;

endpackage

// ===== rtl/core/preamble_length_frame_receiver.sv =====
// Top level of the preamble and length frame receiver.
// Input word register, framing core and result register; depends on plfr_pkg, plfr_core.
//
//  Port group   Dir  Handshake          Word
//  s_*          in   s_valid/s_ready    plfr_in_t  (rx_byte, fifo_free)
//  m_*          out  m_valid/m_ready    plfr_out_t (push, link, glyph and done flags)
//
// One word per cycle sustained while m_ready holds; each result passes the input register, then the result register.
// Throughput is set by the combinational decision between input and result registers.
// Reset (aresetn low, synchronous) empties both registers and restarts the preamble hunt.
// A stalled result holds; the input register still takes a word while it is empty.
module preamble_length_frame_receiver #(
    parameter int BUFFER_DEPTH = plfr_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  plfr_pkg::plfr_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output plfr_pkg::plfr_out_t m_data
);
    import plfr_pkg::*;

    logic      in_valid_reg;
    plfr_in_t  in_data_reg;
    logic      out_valid_reg;
    plfr_out_t out_data_reg;
    plfr_out_t res;
    logic      advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    plfr_core #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .in_word (in_data_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= res;
        end
    end

    a_done_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.frame_done |-> out_data_reg.push_valid)
        else $error("frame end without push");

    a_push_no_glyph: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.push_valid |->
            out_data_reg.glyph_kind == GLYPH_NONE && !out_data_reg.separator)
        else $error("push and glyph in one result");

    a_start_linked: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.text_start |->
            out_data_reg.link_seen && !out_data_reg.push_valid)
        else $error("text start without link or with push");

    a_stall_holds_in: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_ready |=> in_valid_reg)
        else $error("input word lost during stall");

endmodule

// ===== rtl/core/plfr_core.sv =====
// Framing state and per-word decision logic of the frame receiver.
// Holds phase, text mode, text end flag and byte count; decides one result per stepped word.
// Depends on plfr_pkg.
module plfr_core #(
    parameter int BUFFER_DEPTH = plfr_pkg::BUFFER_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  plfr_pkg::plfr_in_t in_word,
    output plfr_pkg::plfr_out_t res
);
    import plfr_pkg::*;

    logic [2:0] phase_reg, phase_next;
    logic       text_mode_reg, text_mode_next;
    logic       text_ended_reg, text_ended_next;
    logic [7:0] bytes_left_reg, bytes_left_next;

    logic [7:0] b;
    logic [7:0] want;

    assign b    = in_word.rx_byte;
    assign want = phase_reg[0] ? PRE_B : PRE_A;

    always_comb begin
        phase_next      = phase_reg;
        text_mode_next  = text_mode_reg;
        text_ended_next = text_ended_reg;
        bytes_left_next = bytes_left_reg;
        res             = '0;
        res.glyph_kind  = GLYPH_NONE;
        if (phase_reg < PH_LENGTH) begin
            phase_next = (b == want) ? phase_reg + 3'd1 : 3'd0;
        end else if (phase_reg == PH_LENGTH) begin
            res.link_seen   = 1'b1;
            bytes_left_next = b;
            phase_next      = PH_BODY;
            if ({1'b0, b} > 9'(BUFFER_DEPTH)) begin
                text_mode_next  = 1'b1;
                text_ended_next = 1'b0;
                bytes_left_next = b + 8'd1;
                res.text_start  = 1'b1;
            end else if ({1'b0, b} + 9'd2 > {3'b000, in_word.fifo_free}) begin
                phase_next      = 3'd0;
                text_mode_next  = 1'b0;
                text_ended_next = 1'b0;
            end else begin
                res.push_valid = 1'b1;
                res.push_data  = b;
            end
        end else begin
            res.link_seen = 1'b1;
            if (text_mode_reg) begin
                if (bytes_left_reg != 8'd1 && !text_ended_reg) begin
                    res.separator = 1'b1;
                    if (b == 8'd0) begin
                        text_ended_next = 1'b1;
                    end else if (b == UNDERSCORE) begin
                        res.glyph_kind = GLYPH_SPACE;
                    end else begin
                        res.glyph_kind = GLYPH_CHAR;
                        res.text_char  = b;
                    end
                end
            end else begin
                res.push_valid = 1'b1;
                res.push_data  = b;
            end
            if (bytes_left_reg != 8'd0) begin
                bytes_left_next = bytes_left_reg - 8'd1;
            end else begin
                res.text_done   = text_mode_reg;
                res.frame_done  = !text_mode_reg;
                phase_next      = 3'd0;
                text_mode_next  = 1'b0;
                text_ended_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= 3'd0;
            text_mode_reg  <= 1'b0;
            text_ended_reg <= 1'b0;
            bytes_left_reg <= 8'd0;
        end else if (step) begin
            phase_reg      <= phase_next;
            text_mode_reg  <= text_mode_next;
            text_ended_reg <= text_ended_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= PH_BODY)
        else $error("phase outside preamble, length and body");

    a_text_in_body: assert property (@(posedge aclk) disable iff (!aresetn)
        text_mode_reg |-> phase_reg == PH_BODY)
        else $error("text mode outside frame body");

    a_ended_in_text: assert property (@(posedge aclk) disable iff (!aresetn)
        text_ended_reg |-> text_mode_reg)
        else $error("text end flag without text mode");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for preamble_length_frame_receiver: sends framed byte words with
// random gaps, stalls and a long result hold-off, and checks every result word in order.
// Depends on plfr_pkg and the preamble_length_frame_receiver RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import plfr_pkg::*;

    localparam int     FRAME_DEPTH  = BUFFER_DEPTH_DEF;
    localparam int     RANDOM_WORDS = 600;
    localparam int     MAX_GAP      = 12;
    localparam int     LONG_HOLD    = 200;
    localparam int     DRAIN_CYCLES = 10;
    localparam longint CYCLE_LIMIT  = 500000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    plfr_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    plfr_out_t m_data;

    logic [2:0] rx_phase     = '0;
    logic       in_text      = 1'b0;
    logic       text_stopped = 1'b0;
    logic [7:0] body_left    = '0;

    plfr_out_t expected_words[$];

    int     error_count    = 0;
    int     words_sent     = 0;
    int     words_checked  = 0;
    int     frames_done    = 0;
    int     frames_dropped = 0;
    int     texts_done     = 0;
    int     hold_request   = 0;
    bit     src_gaps_on    = 1'b1;
    bit     sink_stalls_on = 1'b1;
    longint cycle_count    = 0;

    preamble_length_frame_receiver #(
        .BUFFER_DEPTH(FRAME_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic plfr_out_t decode_byte(input plfr_in_t w);
        plfr_out_t  r;
        logic [7:0] want;
        r = '0;
        if (rx_phase < PH_LENGTH) begin
            want     = rx_phase[0] ? PRE_B : PRE_A;
            rx_phase = (w.rx_byte == want) ? rx_phase + 3'd1 : 3'd0;
        end else begin
            r.link_seen = 1'b1;
            if (rx_phase == PH_LENGTH) begin
                body_left = w.rx_byte;
                rx_phase  = PH_BODY;
                if (int'(w.rx_byte) > FRAME_DEPTH) begin
                    in_text      = 1'b1;
                    text_stopped = 1'b0;
                    body_left    = w.rx_byte + 8'd1;
                    r.text_start = 1'b1;
                end else if (int'(w.rx_byte) + 2 > int'(w.fifo_free)) begin
                    rx_phase     = '0;
                    in_text      = 1'b0;
                    text_stopped = 1'b0;
                    frames_dropped++;
                end else begin
                    r.push_valid = 1'b1;
                    r.push_data  = w.rx_byte;
                end
            end else begin
                if (in_text) begin
                    if (body_left != 8'd1 && !text_stopped) begin
                        r.separator = 1'b1;
                        if (w.rx_byte == UNDERSCORE) begin
                            r.glyph_kind = GLYPH_SPACE;
                        end else if (w.rx_byte != 8'd0) begin
                            r.glyph_kind = GLYPH_CHAR;
                            r.text_char  = w.rx_byte;
                        end else begin
                            text_stopped = 1'b1;
                        end
                    end
                end else begin
                    r.push_valid = 1'b1;
                    r.push_data  = w.rx_byte;
                end
                if (body_left != 8'd0) begin
                    body_left = body_left - 8'd1;
                end else begin
                    if (in_text) begin
                        r.text_done = 1'b1;
                        texts_done++;
                    end else begin
                        r.frame_done = 1'b1;
                        frames_done++;
                    end
                    rx_phase     = '0;
                    in_text      = 1'b0;
                    text_stopped = 1'b0;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [5:0] any_room();
        return 6'($urandom_range(0, 32));
    endfunction

    task automatic send_word(input logic [7:0] value, input logic [5:0] room);
        int       gap;
        plfr_in_t w;
        w.rx_byte   = value;
        w.fifo_free = room;
        gap = src_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        expected_words.push_back(decode_byte(w));
        words_sent++;
    endtask

    task automatic send_preamble();
        send_word(PRE_A, any_room());
        send_word(PRE_B, any_room());
        send_word(PRE_A, any_room());
        send_word(PRE_B, any_room());
    endtask

    task automatic send_normal(input logic [7:0] len, input logic [5:0] room);
        send_preamble();
        send_word(len, room);
        if (int'(len) + 2 <= int'(room)) begin
            repeat (int'(len) + 1) send_word(8'($urandom), any_room());
        end
    endtask

    // body runs length+2 words with an 8-bit count, so 255 gives a single word
    task automatic send_text(input logic [7:0] len, input int zero_at);
        int         count;
        logic [7:0] ch;
        send_preamble();
        send_word(len, any_room());
        count = ((int'(len) + 1) % 256) + 1;
        for (int i = 0; i < count; i++) begin
            if (i == zero_at) begin
                ch = 8'h00;
            end else if ($urandom_range(0, 7) == 0) begin
                ch = UNDERSCORE;
            end else begin
                ch = 8'($urandom_range(1, 255));
            end
            send_word(ch, any_room());
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%t: %s expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic compare_word(input plfr_out_t want, input plfr_out_t got);
        check_field("push_valid", 8'(want.push_valid), 8'(got.push_valid));
        check_field("push_data", want.push_data, got.push_data);
        check_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
        check_field("link_seen", 8'(want.link_seen), 8'(got.link_seen));
        check_field("text_start", 8'(want.text_start), 8'(got.text_start));
        check_field("glyph_kind", 8'(want.glyph_kind), 8'(got.glyph_kind));
        check_field("text_char", want.text_char, got.text_char);
        check_field("separator", 8'(want.separator), 8'(got.separator));
        check_field("text_done", 8'(want.text_done), 8'(got.text_done));
        words_checked++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $display("%t: result word with nothing expected, got %p", $time, m_data);
                error_count++;
            end else begin
                compare_word(expected_words.pop_front(), m_data);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Cycle limit reached with %0d result words outstanding",
                     expected_words.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : result_sink
        int pause;
        m_ready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_request > 0) begin
                pause        = hold_request;
                hold_request = 0;
            end else begin
                pause = sink_stalls_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (pause > 0) begin
                m_ready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // a mismatching byte restarts the hunt and is not retried as a first byte
    task automatic test_preamble_hunt();
        send_word(PRE_A, any_room());
        send_word(PRE_B, any_room());
        send_word(PRE_A, any_room());
        send_word(8'h00, any_room());
        send_word(PRE_A, any_room());
        send_word(PRE_A, any_room());
        send_word(PRE_B, any_room());
        send_word(PRE_A, any_room());
        send_word(PRE_B, any_room());
        send_word(8'hFF, 6'd32);
        send_normal(8'd0, 6'd2);
    endtask

    task automatic test_normal_frames();
        send_normal(8'd0, 6'd0);
        send_normal(8'd0, 6'd1);
        send_normal(8'd5, 6'd7);
        send_normal(8'd5, 6'd6);
        send_normal(8'(FRAME_DEPTH), 6'd32);
        send_normal(8'(FRAME_DEPTH - 2), 6'd32);
    endtask

    task automatic test_text_frames();
        send_text(8'(FRAME_DEPTH + 1), -1);
        send_text(8'(FRAME_DEPTH + 1), 4);
        send_text(8'd255, -1);
        send_text(8'd255, 0);
        send_text(8'd200, 1);
    endtask

    task automatic test_back_pressure();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        hold_request   = LONG_HOLD;
        repeat (4) send_normal(8'($urandom_range(3, 8)), 6'd32);
        send_text(8'(FRAME_DEPTH + 3), -1);
        drain_results();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int         stop_at;
        int         kind;
        int         k;
        logic [7:0] len;
        logic [7:0] good;
        logic [7:0] wrong;
        stop_at = words_sent + RANDOM_WORDS;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 15) == 0) begin
                src_gaps_on    = ($urandom_range(0, 3) != 0);
                sink_stalls_on = ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, FRAME_DEPTH))
                                                  : 8'($urandom_range(0, 10));
                send_normal(len, ($urandom_range(0, 3) == 0) ? any_room() : 6'd32);
            end else if (kind <= 7) begin
                k = $urandom_range(0, 39);
                if (k == 0) begin
                    len = 8'd254;
                end else if (k <= 4) begin
                    len = 8'd255;
                end else begin
                    len = 8'($urandom_range(FRAME_DEPTH + 1, FRAME_DEPTH + 12));
                end
                send_text(len, ($urandom_range(0, 1) == 0) ? -1 : $urandom_range(0, 20));
            end else if (kind == 8) begin
                k = $urandom_range(0, 3);
                for (int i = 0; i < k; i++) send_word(i[0] ? PRE_B : PRE_A, any_room());
                good  = k[0] ? PRE_B : PRE_A;
                wrong = 8'($urandom);
                if (wrong == good) wrong = ~wrong;
                send_word(wrong, any_room());
            end else begin
                repeat ($urandom_range(1, 6)) send_word(8'($urandom), any_room());
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_preamble_hunt();
        test_normal_frames();
        test_text_frames();
        test_back_pressure();
        test_random_traffic();
        drain_results();
        $display("Sent %0d byte words and checked %0d result words", words_sent, words_checked);
        $display("Normal frames completed %0d, dropped %0d; text frames completed %0d",
                 frames_done, frames_dropped, texts_done);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
